// ===== sv/tsp_pkg.sv =====
// ----------------------------------------------------------------------------
// tsp_pkg: shared constants, types and helpers
// Sizes, codes and small functions for the Held-Karp bitmask DP engine.
// ----------------------------------------------------------------------------
package tsp_pkg;

	localparam int MAX_V       = 12;
	localparam int WEIGHT_BITS = 32;
	localparam int COST_BITS   = 36;
	localparam int VB          = $clog2(MAX_V);
	localparam int NVB         = $clog2(MAX_V + 1);
	localparam int DP_BITS     = COST_BITS + 1;
	localparam int SUM_BITS    = ((COST_BITS > WEIGHT_BITS) ? COST_BITS : WEIGHT_BITS) + 1;
	localparam int DP_AW       = MAX_V + VB;
	localparam int EDGE_AW     = 2 * VB;
	localparam int EDGE_DEPTH  = 1 << EDGE_AW;

	typedef logic [VB-1:0]          vtx_t;
	typedef logic [NVB-1:0]         nv_t;
	typedef logic [MAX_V-1:0]       mask_t;
	typedef logic [WEIGHT_BITS-1:0] weight_t;
	typedef logic [DP_BITS-1:0]     cost_t;

	localparam cost_t COST_INF = {1'b1, {COST_BITS{1'b0}}};
	localparam cost_t COST_MAX = {1'b0, {COST_BITS{1'b1}}};

	localparam logic [1:0] CMD_EDGE  = 2'd0;
	localparam logic [1:0] CMD_RUN   = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [3:0] CFG_VCOUNT   = 4'd0;
	localparam logic [3:0] CFG_DIRECTED = 4'd1;

	typedef struct packed {
		logic                en;
		logic [EDGE_AW-1:0]  addr;
		weight_t             weight;
	} edge_wr_t;

	function automatic weight_t fit_weight(input logic [31:0] w);
		logic [WEIGHT_BITS+31:0] t;
		t = {{WEIGHT_BITS{1'b0}}, w};
		return t[WEIGHT_BITS-1:0];
	endfunction

	// vertex count 0 acts as 1, above the built maximum as the maximum
	function automatic nv_t active_nv(input logic [3:0] vc);
		nv_t r;
		if (vc == 4'd0)
			r = NVB'(1);
		else if (int'(vc) > MAX_V)
			r = NVB'(MAX_V);
		else
			r = NVB'(vc);
		return r;
	endfunction

endpackage

// ===== sv/tsp_if.sv =====
// ----------------------------------------------------------------------------
// tsp_if: channel interfaces
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tsp_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [3:0]  from_vertex;
	logic [3:0]  to_vertex;
	logic [31:0] weight;
	logic [3:0]  start_vertex;
	modport source (output valid, cmd, from_vertex, to_vertex, weight, start_vertex,
		input ready);
	modport sink (input valid, cmd, from_vertex, to_vertex, weight, start_vertex,
		output ready);
endinterface

interface tsp_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  goal_vertex;
	logic [35:0] best_cost;
	logic        reachable;
	logic        last_result;
	modport source (output valid, goal_vertex, best_cost, reachable, last_result,
		input ready);
	modport sink (input valid, goal_vertex, best_cost, reachable, last_result,
		output ready);
endinterface

interface tsp_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/tsp_ram.sv =====
// ----------------------------------------------------------------------------
// tsp_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tsp_ram #(
	parameter int WIDTH = 8,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [1 << AW];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ===== sv/tsp_edge_tbl.sv =====
// ----------------------------------------------------------------------------
// tsp_edge_tbl: edge table
// Presence bits in flops (reset clears), weights in a RAM.
// ----------------------------------------------------------------------------
module tsp_edge_tbl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tsp_pkg::edge_wr_t           wr,
	input  logic                        clr,
	input  logic [tsp_pkg::EDGE_AW-1:0] rd_addr,
	input  logic                        rd_en,
	output logic                        rd_present,
	output tsp_pkg::weight_t            rd_weight
);

	logic [tsp_pkg::EDGE_DEPTH-1:0] present_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
		end else if (clr) begin
			present_q <= '0;
		end else if (wr.en) begin
			present_q[wr.addr] <= 1'b1;
		end
	end

	assign rd_present = present_q[rd_addr];

	tsp_ram #(
		.WIDTH(tsp_pkg::WEIGHT_BITS),
		.AW   (tsp_pkg::EDGE_AW)
	) u_wram (
		.clk  (clk),
		.we   (wr.en),
		.waddr(wr.addr),
		.wdata(wr.weight),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_weight)
	);

endmodule

// ===== sv/tsp_bitmask_dp_engine_unit.sv =====
// ----------------------------------------------------------------------------
// tsp_bitmask_dp_engine_unit: Held-Karp TSP engine
// Edge table plus a DP cost RAM walked by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
// Channel  Dir  Beat contents
// req      in   cmd, from_vertex, to_vertex, weight, start_vertex
// rsp      out  goal_vertex, best_cost, reachable, last_result
// cfg      in   index, data (0 vertex_count, 1 directed_mode)
//
// Edge write: directed writes one entry; undirected also writes the reverse
// in ST_EDGE2 (one weight RAM write port). Run: clears all nv * 2^nv DP RAM
// entries, then per (mask, now) a read and check and, if reachable, per next
// a skip or a read then a write back if lower, then per goal a read and a
// load; the single DP RAM port pair sets the pace. Reset clears the sequencer,
// control registers and edge presence bits and sets vertex count 12; DP RAM
// is cleared by every valid run. req is taken only when the sequencer is idle;
// a held rsp beat stalls result loading only.
// ----------------------------------------------------------------------------
module tsp_bitmask_dp_engine_unit (
	input  logic      clk,
	input  logic      arst_n,
	tsp_in_if.sink    req,
	tsp_out_if.source rsp,
	tsp_cfg_if.sink   cfg
);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_EDGE2 = 9'b000000010,
		ST_CLR   = 9'b000000100,
		ST_HREAD = 9'b000001000,
		ST_HCHK  = 9'b000010000,
		ST_NREAD = 9'b000100000,
		ST_NUPD  = 9'b001000000,
		ST_EREAD = 9'b010000000,
		ST_ELOAD = 9'b100000000
	} state_t;

	state_t state_q, state_d, an_state;

	logic [3:0]       vcount_q;
	logic             directed_q;
	tsp_pkg::nv_t     nv;
	tsp_pkg::vtx_t    last_v;
	tsp_pkg::mask_t   full;
	logic [tsp_pkg::MAX_V:0] one_sh;

	tsp_pkg::vtx_t    start_q, now_q, next_q, goal_q, efrom_q, eto_q;
	tsp_pkg::vtx_t    now_d, next_d, goal_d, an_now, an_goal;
	tsp_pkg::mask_t   mask_q, mask_d, an_mask, nm, eset;
	tsp_pkg::weight_t ew_q;
	tsp_pkg::cost_t   here_q;

	// output register
	logic             rsp_valid_q;
	logic [3:0]       rsp_goal_q;
	logic [35:0]      rsp_cost_q;
	logic             rsp_reach_q;
	logic             rsp_last_q;
	logic             rsp_free;

	logic             req_acc, edge_ok, start_ok;

	// DP RAM ports
	logic                      dp_we, dp_re;
	logic [tsp_pkg::DP_AW-1:0] dp_waddr, dp_raddr;
	tsp_pkg::cost_t            dp_wdata, dp_rdata;

	// edge table ports
	tsp_pkg::edge_wr_t         ewr;
	logic                      eclr, erd_en, e_present;
	tsp_pkg::weight_t          e_weight;

	logic                      skip, last_now, last_mask, last_next;
	logic [tsp_pkg::SUM_BITS-1:0] sum;
	tsp_pkg::cost_t            cand;

	assign nv     = tsp_pkg::active_nv(vcount_q);
	assign last_v = tsp_pkg::VB'(nv - tsp_pkg::NVB'(1));
	assign one_sh = (tsp_pkg::MAX_V + 1)'(1) << nv;
	assign full   = one_sh[tsp_pkg::MAX_V-1:0] - tsp_pkg::MAX_V'(1);

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign edge_ok   = (5'(req.from_vertex) < 5'(nv)) && (5'(req.to_vertex) < 5'(nv));
	assign start_ok  = 5'(req.start_vertex) < 5'(nv);

	assign cfg.ready = 1'b1;

	assign rsp.valid       = rsp_valid_q;
	assign rsp.goal_vertex = rsp_goal_q;
	assign rsp.best_cost   = rsp_cost_q;
	assign rsp.reachable   = rsp_reach_q;
	assign rsp.last_result = rsp_last_q;
	assign rsp_free        = !rsp_valid_q || rsp.ready;

	// relaxation helpers
	assign nm        = mask_q | (tsp_pkg::MAX_V'(1) << next_q);
	assign skip      = (next_q == now_q) || !e_present || mask_q[next_q];
	assign last_now  = (now_q == last_v);
	assign last_next = (next_q == last_v);
	assign last_mask = (mask_q == full);
	assign sum  = tsp_pkg::SUM_BITS'(here_q) + tsp_pkg::SUM_BITS'(e_weight);
	assign cand = (sum > tsp_pkg::SUM_BITS'(tsp_pkg::COST_MAX)) ? tsp_pkg::COST_MAX
		: tsp_pkg::DP_BITS'(sum);
	// goal other than start: full set less the start; start: closed tour
	assign eset = (goal_q == start_q) ? full : (full & ~(tsp_pkg::MAX_V'(1) << start_q));

	// where to go once the current 'now' is done
	always_comb begin
		an_state = ST_HREAD;
		an_mask  = mask_q;
		an_now   = now_q + tsp_pkg::VB'(1);
		an_goal  = goal_q;
		if (last_now) begin
			an_now = '0;
			if (last_mask) begin
				an_state = ST_EREAD;
				an_goal  = '0;
			end else begin
				an_mask = mask_q + tsp_pkg::MAX_V'(1);
			end
		end
	end

	// sequencer next state and memory port control
	always_comb begin
		state_d  = state_q;
		mask_d   = mask_q;
		now_d    = now_q;
		next_d   = next_q;
		goal_d   = goal_q;
		dp_we    = 1'b0;
		dp_waddr = {nm, next_q};
		dp_wdata = cand;
		dp_re    = 1'b0;
		dp_raddr = {mask_q, now_q};
		erd_en   = 1'b0;
		ewr.en     = 1'b0;
		ewr.addr   = {tsp_pkg::vtx_t'(req.from_vertex), tsp_pkg::vtx_t'(req.to_vertex)};
		ewr.weight = tsp_pkg::fit_weight(req.weight);
		eclr     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					unique case (req.cmd)
						tsp_pkg::CMD_EDGE: begin
							if (edge_ok) begin
								ewr.en = 1'b1;
								if (!directed_q)
									state_d = ST_EDGE2;
							end
						end
						tsp_pkg::CMD_RUN: begin
							if (start_ok) begin
								state_d = ST_CLR;
								mask_d  = '0;
								now_d   = '0;
							end
						end
						tsp_pkg::CMD_CLEAR: eclr = 1'b1;
						default: ;
					endcase
				end
			end
			ST_EDGE2: begin
				ewr.en     = 1'b1;
				ewr.addr   = {eto_q, efrom_q};
				ewr.weight = ew_q;
				state_d    = ST_IDLE;
			end
			ST_CLR: begin
				dp_we    = 1'b1;
				dp_waddr = {mask_q, now_q};
				dp_wdata = (mask_q == '0 && now_q == start_q) ? '0 : tsp_pkg::COST_INF;
				if (last_now) begin
					now_d = '0;
					if (last_mask) begin
						mask_d  = '0;
						state_d = ST_HREAD;
					end else begin
						mask_d = mask_q + tsp_pkg::MAX_V'(1);
					end
				end else begin
					now_d = now_q + tsp_pkg::VB'(1);
				end
			end
			ST_HREAD: begin
				dp_re   = 1'b1;
				state_d = ST_HCHK;
			end
			ST_HCHK: begin
				if (dp_rdata == tsp_pkg::COST_INF) begin
					state_d = an_state;
					mask_d  = an_mask;
					now_d   = an_now;
					goal_d  = an_goal;
				end else begin
					next_d  = '0;
					state_d = ST_NREAD;
				end
			end
			ST_NREAD, ST_NUPD: begin
				if (state_q == ST_NREAD && !skip) begin
					dp_re    = 1'b1;
					dp_raddr = {nm, next_q};
					erd_en   = 1'b1;
					state_d  = ST_NUPD;
				end else begin
					if (state_q == ST_NUPD)
						dp_we = (cand < dp_rdata);
					if (last_next) begin
						state_d = an_state;
						mask_d  = an_mask;
						now_d   = an_now;
						goal_d  = an_goal;
					end else begin
						next_d  = next_q + tsp_pkg::VB'(1);
						state_d = ST_NREAD;
					end
				end
			end
			ST_EREAD: begin
				dp_raddr = {eset, goal_q};
				if (rsp_free) begin
					dp_re   = 1'b1;
					state_d = ST_ELOAD;
				end
			end
			ST_ELOAD: begin
				if (goal_q == last_v) begin
					state_d = ST_IDLE;
				end else begin
					goal_d  = goal_q + tsp_pkg::VB'(1);
					state_d = ST_EREAD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			vcount_q   <= 4'd12;
			directed_q <= 1'b0;
			mask_q     <= '0;
			now_q      <= '0;
			next_q     <= '0;
			goal_q     <= '0;
			start_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			mask_q  <= mask_d;
			now_q   <= now_d;
			next_q  <= next_d;
			goal_q  <= goal_d;
			if (req_acc && req.cmd == tsp_pkg::CMD_RUN && start_ok)
				start_q <= tsp_pkg::vtx_t'(req.start_vertex);
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					tsp_pkg::CFG_VCOUNT:   vcount_q   <= cfg.data[3:0];
					tsp_pkg::CFG_DIRECTED: directed_q <= cfg.data[0];
					default: ;
				endcase
			end
			if (state_q == ST_ELOAD)
				rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_acc) begin
			efrom_q <= tsp_pkg::vtx_t'(req.from_vertex);
			eto_q   <= tsp_pkg::vtx_t'(req.to_vertex);
			ew_q    <= tsp_pkg::fit_weight(req.weight);
		end
		if (state_q == ST_HCHK)
			here_q <= dp_rdata;
		if (state_q == ST_ELOAD) begin
			rsp_goal_q  <= 4'(goal_q);
			rsp_reach_q <= (dp_rdata != tsp_pkg::COST_INF);
			rsp_cost_q  <= (dp_rdata == tsp_pkg::COST_INF) ? 36'd0
				: dp_rdata[tsp_pkg::COST_BITS-1:0];
			rsp_last_q  <= (goal_q == last_v);
		end
	end

	tsp_ram #(
		.WIDTH(tsp_pkg::DP_BITS),
		.AW   (tsp_pkg::DP_AW)
	) u_dp_ram (
		.clk  (clk),
		.we   (dp_we),
		.waddr(dp_waddr),
		.wdata(dp_wdata),
		.re   (dp_re),
		.raddr(dp_raddr),
		.rdata(dp_rdata)
	);

	tsp_edge_tbl u_edges (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (ewr),
		.clr       (eclr),
		.rd_addr   ({now_q, next_q}),
		.rd_en     (erd_en),
		.rd_present(e_present),
		.rd_weight (e_weight)
	);

	// result register must be free when a goal is loaded
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ELOAD |-> !rsp_valid_q)
		else $error("result loaded over a pending beat");

	// a relaxation never writes back into the mask it reads from
	a_grow_mask: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_NUPD |-> !mask_q[next_q])
		else $error("relaxation target already in mask");

	// result beats appear only after a load cycle
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_ELOAD))
		else $error("result beat without load");

endmodule
